// ----- hdl/sjcc_pkg.sv -----
// Shared types and constants for the servo jog command controller.
// No dependencies; every other file in hdl/ imports this package.
package sjcc_pkg;

    localparam int NUM_JOINTS = 5;
    localparam int JOINT_W    = 3;
    localparam int ANGLE_W    = 15;
    localparam int PULSE_W    = 12;
    localparam int STEP_W     = 16;
    localparam int SLOT_N     = 10;
    localparam int SLOT_IDX_W = 4;
    localparam int IN_DATA_W  = 56;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 15'd18000;
    localparam logic [ANGLE_W-1:0] ANGLE_RESET = 15'd9000;
    localparam logic [ANGLE_W-1:0] ANGLE_GRIP1 = 15'd4500;
    localparam logic [ANGLE_W-1:0] ANGLE_GRIP2 = 15'd9000;

    // Tilt moves in hundredths of a degree
    localparam logic signed [17:0] TILT_BIG   = 18'sd200;
    localparam logic signed [17:0] TILT_SMALL = 18'sd100;

    // Constant reciprocals: x/100, x/180 and x/10 as multiply and shift
    localparam logic [12:0] DEG_RECIP   = 13'd5243;     // 2^19 / 100, rounded up
    localparam logic [20:0] P180_RECIP  = 21'd1491309;  // 2^28 / 180, rounded up
    localparam logic [18:0] TENTH_RECIP = 19'd419431;   // 2^22 / 10, rounded up

    // Configuration register indexes
    localparam logic [2:0] REG_STEP_MIN  = 3'd0;
    localparam logic [2:0] REG_STEP_MAX  = 3'd1;
    localparam logic [2:0] REG_TILT_TH   = 3'd2;
    localparam logic [2:0] REG_PULSE_MIN = 3'd3;
    localparam logic [2:0] REG_PULSE_MAX = 3'd4;

    // Action codes
    localparam logic [2:0] ACT_GRIP45 = 3'd1;
    localparam logic [2:0] ACT_GRIP90 = 3'd2;
    localparam logic [2:0] ACT_PRESET = 3'd4;

    // Write slots, issued lowest first
    localparam logic [SLOT_IDX_W-1:0] SLOT_STEP2 = 4'd0;
    localparam logic [SLOT_IDX_W-1:0] SLOT_STEP0 = 4'd1;
    localparam logic [SLOT_IDX_W-1:0] SLOT_TILT1 = 4'd2;
    localparam logic [SLOT_IDX_W-1:0] SLOT_TILT2 = 4'd3;
    localparam logic [SLOT_IDX_W-1:0] SLOT_TILT3 = 4'd4;
    localparam logic [SLOT_IDX_W-1:0] SLOT_PRE0  = 4'd5;
    localparam logic [SLOT_IDX_W-1:0] SLOT_PRE1  = 4'd6;
    localparam logic [SLOT_IDX_W-1:0] SLOT_PRE2  = 4'd7;
    localparam logic [SLOT_IDX_W-1:0] SLOT_PRE3  = 4'd8;
    localparam logic [SLOT_IDX_W-1:0] SLOT_GRIP  = 4'd9;

    typedef struct packed {
        logic [14:0] step_min;
        logic [14:0] step_max;
        logic [14:0] tilt_th;
        logic [11:0] pulse_min;
        logic [11:0] pulse_max;
    } t_cfg;

    // One classified command
    typedef struct packed {
        logic [SLOT_N-1:0]       slots;
        logic signed [STEP_W-1:0] step2;
        logic [ANGLE_W-1:0]      q0_mag;
        logic                    q0_neg;
        logic                    tilt_neg;
        logic                    grip90;
    } t_cmd;

    // One joint write
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [ANGLE_W-1:0] angle;
        logic               last;
    } t_write;

endpackage

// ----- hdl/sjcc_front.sv -----
// Front end: registers an incoming command, decides which joint writes it causes
// and scales the joint 0 step. Depends on sjcc_pkg.
module sjcc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sjcc_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [55:0]           i_data,
    output logic                  o_push,
    output sjcc_pkg::t_cmd        o_entry,
    input  logic                  i_full
);
    import sjcc_pkg::*;

    logic [2:0]               w_count;
    logic signed [16:0]       w_s2;
    logic signed [16:0]       w_s0;
    logic signed [16:0]       w_tilt;
    logic signed [16:0]       w_th;
    logic [2:0]               w_action;
    logic [16:0]              w_m2;
    logic [16:0]              w_m0;
    logic                     w_ok2;
    logic                     w_ok0;
    logic                     w_tneg;
    logic                     w_tpos;
    logic [SLOT_N-1:0]        w_slots;
    logic                     w_take;
    logic [38:0]              w_prod;

    logic                     r_valid;
    logic [SLOT_N-1:0]        r_slots;
    logic signed [STEP_W-1:0] r_s2;
    logic [19:0]              r_abs9;
    logic                     r_s0_neg;
    logic                     r_tilt_neg;
    logic                     r_grip90;

    always_comb begin
        w_count  = i_data[2:0];
        w_s2     = $signed({i_data[18], i_data[18:3]});
        w_s0     = $signed({i_data[34], i_data[34:19]});
        w_tilt   = $signed({i_data[50], i_data[50:35]});
        w_action = i_data[53:51];
        w_th     = $signed({2'b00, i_cfg.tilt_th});
        w_m2     = w_s2[16] ? 17'(-w_s2) : 17'(w_s2);
        w_m0     = w_s0[16] ? 17'(-w_s0) : 17'(w_s0);
        w_ok2    = (w_m2 >= {2'b00, i_cfg.step_min}) && (w_m2 <= {2'b00, i_cfg.step_max});
        w_ok0    = (w_m0 >= {2'b00, i_cfg.step_min}) && (w_m0 <= {2'b00, i_cfg.step_max});
        w_tneg   = w_tilt < -w_th;
        w_tpos   = w_tilt > w_th;

        w_slots = '0;
        w_slots[SLOT_STEP2] = (w_count >= 3'd1) && w_ok2;
        w_slots[SLOT_STEP0] = (w_count >= 3'd2) && w_ok0;
        w_slots[SLOT_TILT1] = (w_count >= 3'd3) && (w_tneg || w_tpos);
        w_slots[SLOT_TILT2] = w_slots[SLOT_TILT1];
        w_slots[SLOT_TILT3] = w_slots[SLOT_TILT1];
        w_slots[SLOT_PRE0]  = (w_count >= 3'd4) && (w_action == ACT_PRESET);
        w_slots[SLOT_PRE1]  = w_slots[SLOT_PRE0];
        w_slots[SLOT_PRE2]  = w_slots[SLOT_PRE0];
        w_slots[SLOT_PRE3]  = w_slots[SLOT_PRE0];
        w_slots[SLOT_GRIP]  = (w_count >= 3'd4) && ((w_action == ACT_GRIP45) ||
                              (w_action == ACT_GRIP90) || (w_action == ACT_PRESET));
    end

    // Drop commands that write nothing; otherwise wait for queue space
    assign o_ready = !r_valid || !i_full || (r_slots == '0);
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_valid && (r_slots != '0) && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_slots    <= w_slots;
            r_s2       <= i_data[18:3];
            r_abs9     <= {w_m0[16:0], 3'b000} + {3'b000, w_m0[16:0]};
            r_s0_neg   <= w_s0[16];
            r_tilt_neg <= w_tneg;
            r_grip90   <= (w_action == ACT_GRIP90);
        end
    end

    // |step0| * 9 / 10, truncated toward zero
    assign w_prod = r_abs9 * TENTH_RECIP;

    always_comb begin
        o_entry.slots    = r_slots;
        o_entry.step2    = r_s2;
        o_entry.q0_mag   = w_prod[36:22];
        o_entry.q0_neg   = r_s0_neg;
        o_entry.tilt_neg = r_tilt_neg;
        o_entry.grip90   = r_grip90;
    end

endmodule

// ----- hdl/sjcc_queue.sv -----
// Short command queue between the front end and the write sequencer.
// Depends on sjcc_pkg.
module sjcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sjcc_pkg::t_cmd  i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output sjcc_pkg::t_cmd  o_head
);
    import sjcc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hdl/sjcc_issue.sv -----
// Write sequencer: takes classified commands from the queue, issues one joint
// write per cycle unless stalled; keeps five joint angles. Needs sjcc_pkg.
module sjcc_issue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_empty,
    input  sjcc_pkg::t_cmd   i_head,
    output logic             o_pop,
    output logic             o_wr_valid,
    output sjcc_pkg::t_write o_wr
);
    import sjcc_pkg::*;

    logic [SLOT_N-1:0]     r_slots;
    t_cmd                  r_cur;
    logic [ANGLE_W-1:0]    r_angle [NUM_JOINTS];

    logic [SLOT_N-1:0]     w_low;
    logic [SLOT_N-1:0]     w_rest;
    logic [SLOT_IDX_W-1:0] w_sel;
    logic                  w_issue;
    logic [JOINT_W-1:0]    w_joint;
    logic [ANGLE_W-1:0]    w_base;
    logic signed [17:0]    w_delta;
    logic signed [17:0]    w_sum;
    logic [ANGLE_W-1:0]    w_angle;

    always_comb begin
        w_low  = r_slots & (~r_slots + 1'b1);
        w_rest = r_slots & ~w_low;
        w_sel  = '0;
        for (int i = 0; i < SLOT_N; i++) begin
            if (w_low[i]) begin
                w_sel = SLOT_IDX_W'(i);
            end
        end
    end

    assign w_issue = i_adv && (r_slots != '0);
    // Refill when idle or on the cycle the last pending write goes out
    assign o_pop   = !i_empty && ((r_slots == '0) || (w_issue && (w_rest == '0)));

    always_comb begin
        w_joint = 3'd0;
        w_base  = '0;
        w_delta = '0;
        case (w_sel)
            SLOT_STEP2: begin
                w_joint = 3'd2;
                w_base  = r_angle[2];
                w_delta = 18'(r_cur.step2);
            end
            SLOT_STEP0: begin
                w_joint = 3'd0;
                w_base  = r_angle[0];
                w_delta = r_cur.q0_neg ? -$signed({3'b000, r_cur.q0_mag})
                                       :  $signed({3'b000, r_cur.q0_mag});
            end
            SLOT_TILT1: begin
                w_joint = 3'd1;
                w_base  = r_angle[1];
                w_delta = r_cur.tilt_neg ? TILT_BIG : -TILT_BIG;
            end
            SLOT_TILT2: begin
                w_joint = 3'd2;
                w_base  = r_angle[2];
                w_delta = r_cur.tilt_neg ? -TILT_BIG : TILT_BIG;
            end
            SLOT_TILT3: begin
                w_joint = 3'd3;
                w_base  = r_angle[3];
                w_delta = r_cur.tilt_neg ? TILT_SMALL : -TILT_SMALL;
            end
            SLOT_PRE0: begin
                w_joint = 3'd0;
            end
            SLOT_PRE1: begin
                w_joint = 3'd1;
            end
            SLOT_PRE2: begin
                w_joint = 3'd2;
                w_delta = $signed({3'b000, ANGLE_MAX});
            end
            SLOT_PRE3: begin
                w_joint = 3'd3;
                w_delta = $signed({3'b000, ANGLE_RESET});
            end
            SLOT_GRIP: begin
                w_joint = 3'd4;
                w_delta = $signed({3'b000, r_cur.grip90 ? ANGLE_GRIP2 : ANGLE_GRIP1});
            end
            default: begin
                w_joint = 3'd0;
            end
        endcase
        w_sum = $signed({3'b000, w_base}) + w_delta;
        if (w_sum < 18'sd0) begin
            w_angle = '0;
        end else if (w_sum > $signed({3'b000, ANGLE_MAX})) begin
            w_angle = ANGLE_MAX;
        end else begin
            w_angle = w_sum[ANGLE_W-1:0];
        end
    end

    assign o_wr_valid = w_issue;
    always_comb begin
        o_wr.joint = w_joint;
        o_wr.angle = w_angle;
        o_wr.last  = (w_rest == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
            for (int j = 0; j < NUM_JOINTS; j++) begin
                r_angle[j] <= ANGLE_RESET;
            end
        end else begin
            if (o_pop) begin
                r_slots <= i_head.slots;
            end else if (w_issue) begin
                r_slots <= w_rest;
            end
            if (w_issue) begin
                r_angle[w_joint] <= w_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

endmodule

// ----- hdl/sjcc_pulse.sv -----
// Pulse pipeline: maps a joint angle to its servo pulse count in four stages
// (degrees, scale by span, divide by 180, offset). Depends on sjcc_pkg.
module sjcc_pulse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  sjcc_pkg::t_cfg   i_cfg,
    input  logic             i_wr_valid,
    input  sjcc_pkg::t_write i_wr,
    output logic             o_valid,
    output logic [2:0]       o_joint,
    output logic [11:0]      o_pulse,
    output logic             o_last
);
    import sjcc_pkg::*;

    logic               r_b_v;
    logic [JOINT_W-1:0] r_b_joint;
    logic               r_b_last;
    logic [27:0]        r_b_prod;

    logic               r_c_v;
    logic [JOINT_W-1:0] r_c_joint;
    logic               r_c_last;
    logic signed [21:0] r_c_prod;

    logic               r_d_v;
    logic [JOINT_W-1:0] r_d_joint;
    logic               r_d_last;
    logic               r_d_neg;
    logic [40:0]        r_d_prod;

    logic               r_e_v;
    logic [JOINT_W-1:0] r_e_joint;
    logic               r_e_last;
    logic [PULSE_W-1:0] r_e_pulse;

    logic signed [12:0] w_diff;
    logic signed [8:0]  w_deg;
    logic signed [21:0] w_cneg;
    logic [19:0]        w_mag;
    logic [12:0]        w_q;
    logic [12:0]        w_pulse;

    always_comb begin
        w_diff  = $signed({1'b0, i_cfg.pulse_max}) - $signed({1'b0, i_cfg.pulse_min});
        w_deg   = $signed({1'b0, r_b_prod[26:19]});
        w_cneg  = -r_c_prod;
        w_mag   = r_c_prod[21] ? w_cneg[19:0] : r_c_prod[19:0];
        w_q     = {1'b0, r_d_prod[39:28]};
        w_pulse = {1'b0, i_cfg.pulse_min} + (r_d_neg ? -w_q : w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (i_adv) begin
            r_b_v <= i_wr_valid;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_joint <= i_wr.joint;
            r_b_last  <= i_wr.last;
            r_b_prod  <= i_wr.angle * DEG_RECIP;

            r_c_joint <= r_b_joint;
            r_c_last  <= r_b_last;
            r_c_prod  <= w_deg * w_diff;

            r_d_joint <= r_c_joint;
            r_d_last  <= r_c_last;
            r_d_neg   <= r_c_prod[21];
            r_d_prod  <= w_mag * P180_RECIP;

            r_e_joint <= r_d_joint;
            r_e_last  <= r_d_last;
            r_e_pulse <= w_pulse[PULSE_W-1:0];
        end
    end

    assign o_valid = r_e_v;
    assign o_joint = r_e_joint;
    assign o_pulse = r_e_pulse;
    assign o_last  = r_e_last;

endmodule

// ----- hdl/servo_jog_command_controller.sv -----
// Servo jog command controller, top level: config registers, front end, queue,
// write sequencer and pulse pipeline. Depends on sjcc_pkg and the sjcc_* modules.
// A command's first write result passes the front-end register, the queue, the
// sequencer's slot register and the pulse pipeline registers before the output.
// Throughput: one command per cycle at the input while the queue has room; one joint
// write per cycle at the output while i_m_tready does not stall it; the sequencer
// takes the next command only with the last write of the current (at most 10 writes).
// Reset: synchronous, active low; restores the register defaults, angles to 90 deg.
module servo_jog_command_controller #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] field_count, [18:3] joint2_step, [34:19] joint0_step,
    // [50:35] tilt_value, [53:51] action_code, [55:54] zero
    input  logic [55:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [11:0] pulse_count, [15:12] zero
    output logic [15:0] o_m_tdata,
    // [2:0] joint_index
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import sjcc_pkg::*;

    t_cfg   r_cfg;
    t_cmd   w_entry;
    t_cmd   w_head;
    t_write w_wr;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    logic   w_wr_valid;
    logic   w_adv;
    logic   w_valid;
    logic [2:0]  w_joint;
    logic [11:0] w_pulse;
    logic   w_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_min  <= 15'd50;
            r_cfg.step_max  <= 15'd1000;
            r_cfg.tilt_th   <= 15'd70;
            r_cfg.pulse_min <= 12'd150;
            r_cfg.pulse_max <= 12'd600;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STEP_MIN:  r_cfg.step_min  <= i_cfg_data;
                REG_STEP_MAX:  r_cfg.step_max  <= i_cfg_data;
                REG_TILT_TH:   r_cfg.tilt_th   <= i_cfg_data;
                REG_PULSE_MIN: r_cfg.pulse_min <= i_cfg_data[11:0];
                REG_PULSE_MAX: r_cfg.pulse_max <= i_cfg_data[11:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Back end moves only when the output register is free or drains
    assign w_adv = !w_valid || i_m_tready;

    sjcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_push  (w_push),
        .o_entry (w_entry),
        .i_full  (w_full)
    );

    sjcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sjcc_issue u_issue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_wr_valid (w_wr_valid),
        .o_wr       (w_wr)
    );

    sjcc_pulse u_pulse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_cfg      (r_cfg),
        .i_wr_valid (w_wr_valid),
        .i_wr       (w_wr),
        .o_valid    (w_valid),
        .o_joint    (w_joint),
        .o_pulse    (w_pulse),
        .o_last     (w_last)
    );

    assign o_m_tvalid = w_valid;
    assign o_m_tdata  = {4'b0000, w_pulse};
    assign o_m_tuser  = w_joint;
    assign o_m_tlast  = w_last;

endmodule
